/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;
	localparam int DEPTH_DEFAULT = 16;
	localparam int ID_W = 6;
	localparam int PRI_W = 4;
	localparam int PAY_W = 32;
	localparam int FUNC_W = 2;
	localparam int OCC_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} ctl_state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;
endpackage

/* rtl/spq_ctrl.sv */
// Controller: request handshake, result hold state and command decode.
`timescale 1ns / 1ps
module spq_ctrl
	import spq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic [FUNC_W-1:0] func,
	input  dp_status_t        status,
	output ctl_cmd_t          cmd
);
	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		req_stall = (state_q == ST_HOLD) && rsp_stall;
		rsp_valid = (state_q == ST_HOLD);
		accept = req_valid && !req_stall;
		cmd.load = accept;
		cmd.push = accept && (func == FUNC_PUSH) && !status.full;
		cmd.pop = accept && (func == FUNC_POP) && !status.empty;
		cmd.clear = accept && (func == FUNC_CLEAR);
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!rsp_stall && !accept) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* rtl/spq_dp.sv */
// Datapath: row of sorted cells, count, tail tracking and result register.
`timescale 1ns / 1ps
module spq_dp
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	input  logic [ID_W-1:0]  requester_id,
	input  logic [PRI_W-1:0] priority_req,
	input  logic [PAY_W-1:0] payload,
	output dp_status_t       status,
	output logic             accepted,
	output logic [ID_W-1:0]  popped_id,
	output logic [PRI_W-1:0] popped_priority,
	output logic [PAY_W-1:0] popped_payload,
	output logic [OCC_W-1:0] occupancy,
	output logic [ID_W-1:0]  head_id,
	output logic [ID_W-1:0]  tail_id,
	output logic             is_empty
);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [ID_W-1:0]  id_q  [DEPTH];
	logic [PRI_W-1:0] pri_q [DEPTH];
	logic [PAY_W-1:0] pay_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] ge;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [ID_W-1:0]  tail_q;
	logic [ID_W-1:0]  tail_d;
	logic [ID_W-1:0]  head_d;
	logic             empty_d;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic prev_ge;
		assign ge[g] = vld_q[g] && (pri_q[g] >= priority_req);
		if (g == 0) begin : g_first
			assign prev_ge = 1'b1;
		end else begin : g_rest
			assign prev_ge = ge[g-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.push && !ge[g]) begin
				if (prev_ge) begin
					id_q[g] <= requester_id;
					pri_q[g] <= priority_req;
					pay_q[g] <= payload;
				end else begin
					id_q[g] <= id_q[(g == 0) ? 0 : g-1];
					pri_q[g] <= pri_q[(g == 0) ? 0 : g-1];
					pay_q[g] <= pay_q[(g == 0) ? 0 : g-1];
				end
			end else if (cmd.pop && (g < DEPTH - 1)) begin
				id_q[g] <= id_q[(g < DEPTH - 1) ? g+1 : g];
				pri_q[g] <= pri_q[(g < DEPTH - 1) ? g+1 : g];
				pay_q[g] <= pay_q[(g < DEPTH - 1) ? g+1 : g];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (cmd.clear) begin
				vld_q[g] <= 1'b0;
			end else if (cmd.push) begin
				vld_q[g] <= vld_q[g] | ((g == 0) ? 1'b1 : vld_q[(g == 0) ? 0 : g-1]);
			end else if (cmd.pop) begin
				vld_q[g] <= (g == DEPTH - 1) ? 1'b0 : vld_q[(g < DEPTH - 1) ? g+1 : g];
			end
		end
	end

	assign status.full = vld_q[DEPTH-1];
	assign status.empty = !vld_q[0];

	always_comb begin
		count_d = count_q;
		tail_d = tail_q;
		head_d = vld_q[0] ? id_q[0] : '0;
		if (cmd.clear) begin
			count_d = '0;
			head_d = '0;
		end else if (cmd.push) begin
			count_d = count_q + CNT_W'(1);
			if (ge == vld_q) begin
				tail_d = requester_id;
			end
			if (!ge[0]) begin
				head_d = requester_id;
			end
		end else if (cmd.pop) begin
			count_d = count_q - CNT_W'(1);
			head_d = vld_q[1] ? id_q[1] : '0;
		end
		empty_d = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tail_q <= '0;
		end else begin
			count_q <= count_d;
			tail_q <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			accepted <= cmd.push | cmd.pop | cmd.clear;
			popped_id <= cmd.pop ? id_q[0] : '0;
			popped_priority <= cmd.pop ? pri_q[0] : '0;
			popped_payload <= cmd.pop ? pay_q[0] : '0;
			occupancy <= OCC_W'(count_d);
			head_id <= head_d;
			tail_id <= empty_d ? '0 : tail_d;
			is_empty <= empty_d;
		end
	end
endmodule

/* rtl/sorted_priority_queue_top.sv */
// Top level of the stable sorted priority queue.
`timescale 1ns / 1ps
// A bounded queue of DEPTH entries kept sorted in a row of cells, highest
// priority at the head; a push lands behind every entry of equal or higher
// priority, so equal priorities leave in arrival order. On every request (push,
// pop or clear) all cells compare against the new priority and shift in the
// same cycle, and the result is held in an output register, so a new request
// is taken each cycle unless a held result is stalled. Each request gives
// exactly one result.
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [ID_W-1:0]   requester_id,
	input  logic [PRI_W-1:0]  priority_req,
	input  logic [PAY_W-1:0]  payload,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              accepted,
	output logic [ID_W-1:0]   popped_id,
	output logic [PRI_W-1:0]  popped_priority,
	output logic [PAY_W-1:0]  popped_payload,
	output logic [OCC_W-1:0]  occupancy,
	output logic [ID_W-1:0]   head_id,
	output logic [ID_W-1:0]   tail_id,
	output logic              is_empty
);
	ctl_cmd_t   cmd;
	dp_status_t status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.func      (func),
		.status    (status),
		.cmd       (cmd)
	);

	spq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.requester_id    (requester_id),
		.priority_req    (priority_req),
		.payload         (payload),
		.status          (status),
		.accepted        (accepted),
		.popped_id       (popped_id),
		.popped_priority (popped_priority),
		.popped_payload  (popped_payload),
		.occupancy       (occupancy),
		.head_id         (head_id),
		.tail_id         (tail_id),
		.is_empty        (is_empty)
	);
endmodule

/* tb/sorted_priority_queue_top_tb.sv */
// Self-checking testbench for the stable sorted priority queue top level.
`timescale 1ns / 1ps
module sorted_priority_queue_top_tb;
	import spq_pkg::*;

	localparam int QDEPTH = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQUESTS = 1600;
	localparam int QUIET_TAIL = 150;
	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

	typedef struct packed {
		logic             accepted;
		logic [ID_W-1:0]  popped_id;
		logic [PRI_W-1:0] popped_pri;
		logic [PAY_W-1:0] popped_pay;
		logic [OCC_W-1:0] occupancy;
		logic [ID_W-1:0]  head_id;
		logic [ID_W-1:0]  tail_id;
		logic             is_empty;
	} spq_result_t;

	class spq_scoreboard;
		logic [ID_W-1:0]  ids[QDEPTH];
		logic [PRI_W-1:0] pris[QDEPTH];
		logic [PAY_W-1:0] pays[QDEPTH];
		int               count;
		spq_result_t      expected_q[$];
		int               errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Updates the queue image for one accepted request and stores the result it implies.
		function void note_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
				input logic [PRI_W-1:0] pri, input logic [PAY_W-1:0] pay);
			spq_result_t r;
			int pos;
			r = '0;
			case (f)
				FUNC_PUSH: begin
					if (count < QDEPTH) begin
						pos = 0;
						while (pos < count && pris[pos] >= pri)
							pos++;
						for (int i = count; i > pos; i--) begin
							ids[i] = ids[i-1];
							pris[i] = pris[i-1];
							pays[i] = pays[i-1];
						end
						ids[pos] = id;
						pris[pos] = pri;
						pays[pos] = pay;
						count++;
						r.accepted = 1'b1;
					end
				end
				FUNC_POP: begin
					if (count > 0) begin
						r.accepted = 1'b1;
						r.popped_id = ids[0];
						r.popped_pri = pris[0];
						r.popped_pay = pays[0];
						for (int i = 0; i + 1 < count; i++) begin
							ids[i] = ids[i+1];
							pris[i] = pris[i+1];
							pays[i] = pays[i+1];
						end
						count--;
					end
				end
				FUNC_CLEAR: begin
					count = 0;
					r.accepted = 1'b1;
				end
				default: begin
				end
			endcase
			r.occupancy = count[OCC_W-1:0];
			r.head_id = (count > 0) ? ids[0] : '0;
			r.tail_id = (count > 0) ? ids[count-1] : '0;
			r.is_empty = (count == 0);
			expected_q.push_back(r);
		endfunction

		task check_response(input spq_result_t got);
			spq_result_t exp_r;
			if (expected_q.size() == 0) begin
				report("response arrived with no request outstanding");
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.accepted !== exp_r.accepted)
				report($sformatf("accepted %0b, expected %0b", got.accepted, exp_r.accepted));
			if (got.popped_id !== exp_r.popped_id)
				report($sformatf("popped_id %0d, expected %0d", got.popped_id, exp_r.popped_id));
			if (got.popped_pri !== exp_r.popped_pri)
				report($sformatf("popped_priority %0d, expected %0d",
					got.popped_pri, exp_r.popped_pri));
			if (got.popped_pay !== exp_r.popped_pay)
				report($sformatf("popped_payload %h, expected %h",
					got.popped_pay, exp_r.popped_pay));
			if (got.occupancy !== exp_r.occupancy)
				report($sformatf("occupancy %0d, expected %0d", got.occupancy, exp_r.occupancy));
			if (got.head_id !== exp_r.head_id)
				report($sformatf("head_id %0d, expected %0d", got.head_id, exp_r.head_id));
			if (got.tail_id !== exp_r.tail_id)
				report($sformatf("tail_id %0d, expected %0d", got.tail_id, exp_r.tail_id));
			if (got.is_empty !== exp_r.is_empty)
				report($sformatf("is_empty %0b, expected %0b", got.is_empty, exp_r.is_empty));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [FUNC_W-1:0] func = FUNC_PUSH;
	logic [ID_W-1:0]   requester_id = '0;
	logic [PRI_W-1:0]  priority_req = '0;
	logic [PAY_W-1:0]  payload = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              accepted;
	logic [ID_W-1:0]   popped_id;
	logic [PRI_W-1:0]  popped_priority;
	logic [PAY_W-1:0]  popped_payload;
	logic [OCC_W-1:0]  occupancy;
	logic [ID_W-1:0]   head_id;
	logic [ID_W-1:0]   tail_id;
	logic              is_empty;

	logic              quiet = 1'b0;
	int                cycles = 0;
	spq_scoreboard     sb;

	sorted_priority_queue_top #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.requester_id(requester_id),
		.priority_req(priority_req),
		.payload(payload),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.accepted(accepted),
		.popped_id(popped_id),
		.popped_priority(popped_priority),
		.popped_payload(popped_payload),
		.occupancy(occupancy),
		.head_id(head_id),
		.tail_id(tail_id),
		.is_empty(is_empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The response is checked before the request of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (rsp_valid && !rsp_stall)
				sb.check_response({accepted, popped_id, popped_priority, popped_payload,
					occupancy, head_id, tail_id, is_empty});
			if (req_valid && !req_stall)
				sb.note_request(func, requester_id, priority_req, payload);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri, input logic [PAY_W-1:0] pay);
		@(negedge clk);
		req_valid <= 1'b1;
		func <= f;
		requester_id <= id;
		priority_req <= pri;
		payload <= pay;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			req_valid <= 1'b0;
			func <= 2'($urandom);
			requester_id <= 6'($urandom);
			priority_req <= 4'($urandom);
			payload <= $urandom;
		end
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		logic [PRI_W-1:0] fill_pri[16] = '{4'd15, 4'd0, 4'd7, 4'd7, 4'd15, 4'd0, 4'd3, 4'd12,
			4'd7, 4'd0, 4'd15, 4'd9, 4'd1, 4'd14, 4'd7, 4'd8};
		logic [ID_W-1:0]  id;
		logic [PAY_W-1:0] pay;
		send_request(FUNC_POP, 6'd5, 4'd3, 32'h1234_5678);
		send_request(FUNC_NOP, 6'd63, 4'd15, 32'hFFFF_FFFF);
		send_request(FUNC_CLEAR, 6'd0, 4'd0, 32'h0);
		for (int i = 0; i < QDEPTH; i++) begin
			id = (i == 0) ? 6'd63 : (i == 1) ? 6'd0 : 6'($urandom);
			pay = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : $urandom;
			send_request(FUNC_PUSH, id, fill_pri[i % 16], pay);
		end
		send_request(FUNC_PUSH, 6'd42, 4'd15, 32'hA5A5_A5A5);
		send_request(FUNC_NOP, 6'd1, 4'd1, 32'h1);
		send_request(FUNC_POP, 6'd0, 4'd0, 32'h0);
		send_request(FUNC_POP, 6'd0, 4'd0, 32'h0);
		send_request(FUNC_CLEAR, 6'd63, 4'd15, 32'hFFFF_FFFF);
		send_request(FUNC_POP, 6'd0, 4'd0, 32'h0);
	endtask

	task automatic run_random(input int n);
		int               push_pct;
		int               roll;
		logic             narrow;
		logic [FUNC_W-1:0] f;
		logic [PRI_W-1:0] pri;
		push_pct = 50;
		narrow = 1'b0;
		for (int k = 0; k < n; k++) begin
			if (k % 64 == 0) begin
				push_pct = $urandom_range(25, 80);
				narrow = ($urandom_range(0, 2) == 0);
			end
			if (k == n / 2)
				wait_for_drain();
			if (k == n - QUIET_TAIL)
				quiet = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				f = FUNC_CLEAR;
			else if (roll < 5)
				f = FUNC_NOP;
			else if (roll < 5 + push_pct)
				f = FUNC_PUSH;
			else
				f = FUNC_POP;
			pri = narrow ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
			send_request(f, 6'($urandom), pri, $urandom);
			if (!quiet && $urandom_range(0, 4) == 0)
				idle_sender($urandom_range(1, 3));
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random(RANDOM_REQUESTS);
		wait_for_drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_tb.sv
